// ----- src/bcd_pkg.sv -----
// Shared types and codes for the button click detector.
`default_nettype none

package bcd_pkg;

    // Event codes carried on held_event and fired_event
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_SINGLE = 3'd4,
        EV_DOUBLE = 3'd5,
        EV_LSTART = 3'd6,
        EV_LHOLD  = 3'd7
    } event_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ACTIVE_LEVEL   = 2'd0,
        CFG_DEBOUNCE_COUNT = 2'd1,
        CFG_SHORT_LIMIT    = 2'd2,
        CFG_LONG_LIMIT     = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_DATA_WIDTH = 16;
    localparam int unsigned LIMIT_WIDTH    = 16;
    localparam int unsigned DEB_WIDTH      = 3;
    localparam int unsigned COUNT_WIDTH    = 4;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // One result word
    typedef struct packed {
        event_t                 held_event;
        logic                   event_fired;
        event_t                 fired_event;
        logic                   repeat_hit;
        logic [COUNT_WIDTH-1:0] press_count;
    } result_t;

endpackage

`default_nettype wire

// ----- src/button_click_detector_top.sv -----
// Top level of the button click detector: registers, config and handshakes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid / in_stall   | raw_level
//  out     | output    | out_valid / out_stall | held_event, event_fired,
//          |           |                       | fired_event, repeat_hit, press_count
//  cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One sample a cycle while in_stall is low: a word waits in the input register,
// then the debouncer and click machine update and write the result register.
// out_valid rises once the word has moved from the input register into the
// result register.
// Reset clears all control state and loads the register defaults.
// A stall on out holds the result register; in stalls only when both
// registers are full and the result is not taken.
`default_nettype none

module button_click_detector_top #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 raw_level,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [2:0]                                held_event,
    output logic                                      event_fired,
    output logic [2:0]                                fired_event,
    output logic                                      repeat_hit,
    output logic [bcd_pkg::COUNT_WIDTH-1:0]           press_count,
    input  wire logic                                 cfg_we,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [bcd_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

    logic                               active_reg;
    logic [bcd_pkg::DEB_WIDTH-1:0]      deb_count_reg;
    logic [bcd_pkg::LIMIT_WIDTH-1:0]    short_reg;
    logic [bcd_pkg::LIMIT_WIDTH-1:0]    long_reg;
    logic                               in_valid_reg;
    logic                               raw_reg;
    logic                               out_valid_reg;
    bcd_pkg::result_t                   out_reg;
    bcd_pkg::result_t                   result;
    logic                               advance;
    logic                               stable_now;
    logic                               set_level;

    assign set_level = cfg_we && (cfg_index == bcd_pkg::CFG_ACTIVE_LEVEL);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            deb_count_reg <= bcd_pkg::DEB_WIDTH'(3);
            short_reg     <= bcd_pkg::LIMIT_WIDTH'(60);
            long_reg      <= bcd_pkg::LIMIT_WIDTH'(200);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bcd_pkg::CFG_ACTIVE_LEVEL:   active_reg    <= cfg_wdata[0];
                bcd_pkg::CFG_DEBOUNCE_COUNT: deb_count_reg <= cfg_wdata[bcd_pkg::DEB_WIDTH-1:0];
                bcd_pkg::CFG_SHORT_LIMIT:    short_reg     <= cfg_wdata[bcd_pkg::LIMIT_WIDTH-1:0];
                bcd_pkg::CFG_LONG_LIMIT:     long_reg      <= cfg_wdata[bcd_pkg::LIMIT_WIDTH-1:0];
                default:                     active_reg    <= active_reg;
            endcase
        end
    end

    // Move the input word into the result register when there is room
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            raw_reg <= raw_level;
        end
    end

    bcd_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .raw_level      (raw_reg),
        .debounce_count (deb_count_reg),
        .set_level      (set_level),
        .set_value      (cfg_wdata[0]),
        .stable_now     (stable_now)
    );

    bcd_fsm #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pressed     (stable_now == active_reg),
        .short_limit (short_reg),
        .long_limit  (long_reg),
        .result      (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign held_event  = out_reg.held_event;
    assign event_fired = out_reg.event_fired;
    assign fired_event = out_reg.fired_event;
    assign repeat_hit  = out_reg.repeat_hit;
    assign press_count = out_reg.press_count;

    // A quiet tick carries no event code
    a_quiet_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !event_fired) |-> (fired_event == bcd_pkg::EV_NONE))
        else $error("fired_event set without event_fired");

    // A repeat hit only comes with a press down
    a_repeat_down: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && repeat_hit) |-> (event_fired && fired_event == bcd_pkg::EV_DOWN))
        else $error("repeat_hit without press down");

    // A fired event is latched as the held event
    a_held_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_fired) |-> (held_event == fired_event))
        else $error("held_event does not match fired event");

    // Input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without back-pressure");

endmodule

`default_nettype wire

// ----- src/bcd_debounce.sv -----
// Debouncer: moves the stable level after enough differing samples in a row.
`default_nettype none

module bcd_debounce (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic                           raw_level,
    input  wire logic [bcd_pkg::DEB_WIDTH-1:0]  debounce_count,
    input  wire logic                           set_level,
    input  wire logic                           set_value,
    output logic                                stable_now
);

    logic                          stable_reg;
    logic                          stable_next;
    logic [bcd_pkg::DEB_WIDTH-1:0] cnt_reg;
    logic [bcd_pkg::DEB_WIDTH-1:0] cnt_next;
    logic [bcd_pkg::DEB_WIDTH-1:0] cnt_inc;

    // Count differing samples; flip the stable level at the threshold
    always_comb
    begin
        cnt_inc     = cnt_reg + 1'b1;
        stable_next = stable_reg;
        cnt_next    = '0;
        if (raw_level != stable_reg)
        begin
            if (cnt_inc >= debounce_count)
            begin
                stable_next = raw_level;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    assign stable_now = stable_next;

    // Hold debounce state; a write of the active level forces released
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (set_level)
        begin
            stable_reg <= ~set_value;
        end
        else if (advance)
        begin
            stable_reg <= stable_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bcd_fsm.sv -----
// Click state machine: turns the debounced level into button events.
`default_nettype none

module bcd_fsm #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire logic                             pressed,
    input  wire logic [bcd_pkg::LIMIT_WIDTH-1:0]  short_limit,
    input  wire logic [bcd_pkg::LIMIT_WIDTH-1:0]  long_limit,
    output bcd_pkg::result_t                      result
);

    localparam int unsigned CW =
        (TICK_WIDTH > bcd_pkg::LIMIT_WIDTH) ? TICK_WIDTH : bcd_pkg::LIMIT_WIDTH;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_PRESSED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_REPRESS  = 3'd3,
        ST_LONG     = 3'd5
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [TICK_WIDTH-1:0]                tick_reg;
    logic [TICK_WIDTH-1:0]                tick_next;
    logic [TICK_WIDTH-1:0]                tick_inc;
    logic [bcd_pkg::COUNT_WIDTH-1:0]      rep_reg;
    logic [bcd_pkg::COUNT_WIDTH-1:0]      rep_next;
    bcd_pkg::event_t                      last_reg;
    bcd_pkg::event_t                      last_next;
    logic                                 fired;
    bcd_pkg::event_t                      code;
    logic                                 rep_hit;
    logic [CW-1:0]                        tick_ext;
    logic [CW-1:0]                        short_ext;
    logic [CW-1:0]                        long_ext;

    // Advance the tick count while a sequence is open
    always_comb
    begin
        if (state_reg != ST_IDLE && tick_reg != TICK_MAX)
        begin
            tick_inc = tick_reg + 1'b1;
        end
        else
        begin
            tick_inc = tick_reg;
        end
        tick_ext  = CW'(tick_inc);
        short_ext = CW'(short_limit);
        long_ext  = CW'(long_limit);
    end

    // Next state and event decode
    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_inc;
        rep_next   = rep_reg;
        last_next  = last_reg;
        fired      = 1'b0;
        code       = bcd_pkg::EV_NONE;
        rep_hit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pressed)
                begin
                    fired      = 1'b1;
                    code       = bcd_pkg::EV_DOWN;
                    tick_next  = '0;
                    rep_next   = bcd_pkg::COUNT_WIDTH'(1);
                    state_next = ST_PRESSED;
                end
                else
                begin
                    last_next = bcd_pkg::EV_NONE;
                end
            end
            ST_PRESSED:
            begin
                if (!pressed)
                begin
                    fired      = 1'b1;
                    code       = bcd_pkg::EV_UP;
                    tick_next  = '0;
                    state_next = ST_RELEASED;
                end
                else if (tick_ext > long_ext)
                begin
                    fired      = 1'b1;
                    code       = bcd_pkg::EV_LSTART;
                    state_next = ST_LONG;
                end
            end
            ST_RELEASED:
            begin
                if (pressed)
                begin
                    fired   = 1'b1;
                    code    = bcd_pkg::EV_DOWN;
                    rep_hit = 1'b1;
                    if (rep_reg != bcd_pkg::COUNT_MAX)
                    begin
                        rep_next = rep_reg + 1'b1;
                    end
                    tick_next  = '0;
                    state_next = ST_REPRESS;
                end
                else if (tick_ext > short_ext)
                begin
                    // Click counts above two close silently
                    if (rep_reg == bcd_pkg::COUNT_WIDTH'(1))
                    begin
                        fired = 1'b1;
                        code  = bcd_pkg::EV_SINGLE;
                    end
                    else if (rep_reg == bcd_pkg::COUNT_WIDTH'(2))
                    begin
                        fired = 1'b1;
                        code  = bcd_pkg::EV_DOUBLE;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REPRESS:
            begin
                if (!pressed)
                begin
                    fired = 1'b1;
                    code  = bcd_pkg::EV_UP;
                    if (tick_ext < short_ext)
                    begin
                        tick_next  = '0;
                        state_next = ST_RELEASED;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LONG:
            begin
                fired = 1'b1;
                if (pressed)
                begin
                    code = bcd_pkg::EV_LHOLD;
                end
                else
                begin
                    code       = bcd_pkg::EV_UP;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (fired)
        begin
            last_next = code;
        end
    end

    // Pack the result word
    always_comb
    begin
        result.held_event  = last_next;
        result.event_fired = fired;
        result.fired_event = code;
        result.repeat_hit  = rep_hit;
        result.press_count = rep_next;
    end

    // Hold machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            rep_reg   <= '0;
            last_reg  <= bcd_pkg::EV_NONE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            rep_reg   <= rep_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire
